// ===== src/nlp_pkg.sv =====
package nlp_pkg;

  // word store depth and derived index widths
  localparam int unsigned MAX_LEN = 32;
  localparam int unsigned IDX_W   = $clog2(MAX_LEN);
  localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned CHAR_W  = 8;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // store the incoming character, bump the length
    logic clr_len;   // run finished, start a new word
    logic piv_init;  // a = n-2, b = n-1
    logic piv_step;  // a--, b--
    logic piv_hit;   // latch pivot index and character, b = n-1
    logic suc_step;  // b--
    logic wr_i;      // store[pivot] = successor character
    logic wr_j;      // store[b] = pivot character, a = pivot+1, b = n-1
    logic rev_lo;    // store[a] = character read at b
    logic rev_hi;    // store[b] = character read at a, a++, b--
    logic out_init;  // a = 0
    logic out_char;  // load the output register with a character, a++
    logic out_none;  // load the output register with the not-found item
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic len_lt2;   // fewer than two characters stored
    logic less;      // character at a below character at b
    logic gt;        // character at b above the pivot character
    logic a_zero;    // a is the first position
    logic a_lt_b;    // a below b
    logic a_is_last; // a is the final position of the word
    logic out_free;  // output register can take a request this cycle
  } dp_sts_t;

endpackage

// ===== src/nlp_datapath.sv =====
module nlp_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nlp_pkg::dp_cmd_t           cmd_i,
  output nlp_pkg::dp_sts_t           sts_o,
  input  logic [nlp_pkg::CHAR_W-1:0] char_i,
  output logic [nlp_pkg::CHAR_W-1:0] char_o,
  output logic                       found_o,
  output logic                       last_o,
  output logic                       valid_o,
  input  logic                       ready_i
);

  localparam int unsigned IW = nlp_pkg::IDX_W;
  localparam int unsigned LW = nlp_pkg::LEN_W;
  localparam int unsigned CW = nlp_pkg::CHAR_W;

  // word store, one write port and two registered read ports
  logic [CW-1:0] mem_q [nlp_pkg::MAX_LEN];
  logic [CW-1:0] rda_q, rdb_q;

  logic [LW-1:0] len_q, len_d;
  logic [IW-1:0] a_q, a_d, b_q, b_d;
  logic [IW-1:0] piv_q, piv_d;
  logic [CW-1:0] pch_q, pch_d;

  logic [CW-1:0] och_q, och_d;
  logic          ofound_q, ofound_d, olast_q, olast_d, ovalid_q, ovalid_d;

  logic          len_full;
  logic [LW-1:0] len_m1, len_m2;

  logic          we;
  logic [IW-1:0] waddr;
  logic [CW-1:0] wdata;

  assign len_full = (len_q == LW'(nlp_pkg::MAX_LEN));
  assign len_m1   = LW'(len_q - LW'(1));
  assign len_m2   = LW'(len_q - LW'(2));

  // status toward the controller
  always_comb begin
    sts_o.len_lt2   = (len_q < LW'(2));
    sts_o.less      = (rda_q < rdb_q);
    sts_o.gt        = (rdb_q > pch_q);
    sts_o.a_zero    = (a_q == '0);
    sts_o.a_lt_b    = (a_q < b_q);
    sts_o.a_is_last = (LW'(a_q) == len_m1);
    sts_o.out_free  = !ovalid_q || ready_i;
  end

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = a_q;
    wdata = rdb_q;
    if (cmd_i.load && !len_full) begin
      we    = 1'b1;
      waddr = len_q[IW-1:0];
      wdata = char_i;
    end else if (cmd_i.wr_i) begin
      we    = 1'b1;
      waddr = piv_q;
      wdata = rdb_q;
    end else if (cmd_i.wr_j) begin
      we    = 1'b1;
      waddr = b_q;
      wdata = pch_q;
    end else if (cmd_i.rev_lo) begin
      we    = 1'b1;
      waddr = a_q;
      wdata = rdb_q;
    end else if (cmd_i.rev_hi) begin
      we    = 1'b1;
      waddr = b_q;
      wdata = rda_q;
    end
  end

  // store and read ports
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rda_q <= mem_q[a_q];
    rdb_q <= mem_q[b_q];
  end

  // index and pivot registers
  always_comb begin
    len_d = len_q;
    a_d   = a_q;
    b_d   = b_q;
    piv_d = piv_q;
    pch_d = pch_q;
    if (cmd_i.load && !len_full) begin
      len_d = LW'(len_q + LW'(1));
    end
    if (cmd_i.clr_len) begin
      len_d = '0;
    end
    if (cmd_i.piv_init) begin
      a_d = len_m2[IW-1:0];
      b_d = len_m1[IW-1:0];
    end
    if (cmd_i.piv_step) begin
      a_d = IW'(a_q - IW'(1));
      b_d = IW'(b_q - IW'(1));
    end
    if (cmd_i.piv_hit) begin
      piv_d = a_q;
      pch_d = rda_q;
      b_d   = len_m1[IW-1:0];
    end
    if (cmd_i.suc_step) begin
      b_d = IW'(b_q - IW'(1));
    end
    if (cmd_i.wr_j) begin
      a_d = IW'(piv_q + IW'(1));
      b_d = len_m1[IW-1:0];
    end
    if (cmd_i.rev_hi) begin
      a_d = IW'(a_q + IW'(1));
      b_d = IW'(b_q - IW'(1));
    end
    if (cmd_i.out_init) begin
      a_d = '0;
    end
    if (cmd_i.out_char) begin
      a_d = IW'(a_q + IW'(1));
    end
  end

  // output register
  always_comb begin
    och_d    = och_q;
    ofound_d = ofound_q;
    olast_d  = olast_q;
    ovalid_d = ovalid_q && !ready_i;
    if (cmd_i.out_char) begin
      och_d    = rda_q;
      ofound_d = 1'b1;
      olast_d  = sts_o.a_is_last;
      ovalid_d = 1'b1;
    end else if (cmd_i.out_none) begin
      och_d    = '0;
      ofound_d = 1'b0;
      olast_d  = 1'b1;
      ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      len_q    <= len_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    piv_q    <= piv_d;
    pch_q    <= pch_d;
    och_q    <= och_d;
    ofound_q <= ofound_d;
    olast_q  <= olast_d;
  end

  assign char_o  = och_q;
  assign found_o = ofound_q;
  assign last_o  = olast_q;
  assign valid_o = ovalid_q;

  // a full store keeps its length
  a_len_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && len_full && !cmd_i.clr_len) |=> (len_q == LW'(nlp_pkg::MAX_LEN)))
    else $error("length grew past the store depth");

  // the successor always lies right of the pivot
  a_swap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_i |-> (piv_q < b_q))
    else $error("successor not right of pivot");

  // reversal only swaps an ordered pair
  a_rev_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rev_lo |-> (a_q < b_q))
    else $error("reversal pointers crossed");

  // the final character of a run clears the word
  a_last_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_char && sts_o.a_is_last) |=> (len_q == '0) && olast_q && valid_o)
    else $error("word not cleared after final character");

endmodule

// ===== src/nlp_ctrl.sv =====
module nlp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  nlp_pkg::dp_sts_t sts_i,
  output nlp_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_PIV_RD,
    S_PIV_CMP,
    S_SUC_RD,
    S_SUC_CMP,
    S_SWAP_I,
    S_SWAP_J,
    S_REV_RD,
    S_REV_LO,
    S_REV_HI,
    S_OUT_RD,
    S_OUT_WR,
    S_NONE
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) state_d = S_START;
        end
      end
      S_START: begin
        if (sts_i.len_lt2) begin
          state_d = S_NONE;
        end else begin
          cmd_o.piv_init = 1'b1;
          state_d        = S_PIV_RD;
        end
      end
      S_PIV_RD: state_d = S_PIV_CMP;
      S_PIV_CMP: begin
        if (sts_i.less) begin
          cmd_o.piv_hit = 1'b1;
          state_d       = S_SUC_RD;
        end else if (sts_i.a_zero) begin
          state_d = S_NONE;
        end else begin
          cmd_o.piv_step = 1'b1;
          state_d        = S_PIV_RD;
        end
      end
      S_SUC_RD: state_d = S_SUC_CMP;
      S_SUC_CMP: begin
        if (sts_i.gt) begin
          state_d = S_SWAP_I;
        end else begin
          cmd_o.suc_step = 1'b1;
          state_d        = S_SUC_RD;
        end
      end
      S_SWAP_I: begin
        cmd_o.wr_i = 1'b1;
        state_d    = S_SWAP_J;
      end
      S_SWAP_J: begin
        cmd_o.wr_j = 1'b1;
        state_d    = S_REV_RD;
      end
      S_REV_RD: state_d = S_REV_LO;
      S_REV_LO: begin
        if (sts_i.a_lt_b) begin
          cmd_o.rev_lo = 1'b1;
          state_d      = S_REV_HI;
        end else begin
          cmd_o.out_init = 1'b1;
          state_d        = S_OUT_RD;
        end
      end
      S_REV_HI: begin
        cmd_o.rev_hi = 1'b1;
        state_d      = S_REV_RD;
      end
      S_OUT_RD: state_d = S_OUT_WR;
      S_OUT_WR: begin
        if (sts_i.out_free) begin
          cmd_o.out_char = 1'b1;
          if (sts_i.a_is_last) begin
            cmd_o.clr_len = 1'b1;
            state_d       = S_LOAD;
          end else begin
            state_d = S_OUT_RD;
          end
        end
      end
      S_NONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_none = 1'b1;
          cmd_o.clr_len  = 1'b1;
          state_d        = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // a run always ends by handing over a request
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD && state_d == S_LOAD) |-> (cmd_o.out_char || cmd_o.out_none))
    else $error("run ended without a result");

  // the store write commands are mutually exclusive
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.load, cmd_o.wr_i, cmd_o.wr_j, cmd_o.rev_lo, cmd_o.rev_hi}) <= 1)
    else $error("two store writes in one cycle");

endmodule

// ===== src/next_lexicographic_permutation_core.sv =====
// channel  | dir | tdata (low bit up)  | tuser | tlast
// s_axis   | in  | char_in[7:0]        | -     | last_in
// m_axis   | out | char_out[7:0]       | found | last_out
//
// characters load at one per cycle while in the load state; a word of n
// characters is then handled by scanning for the pivot, scanning for its
// successor, the swap, reversing the suffix pair by pair and sending each
// output character, paced by the registered reads and the single write port of the store
// after reset the block is ready to load; the store itself is not cleared
// a stalled output holds one request in its register; later requests wait for it

module next_lexicographic_permutation_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // char_in[7:0]
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // char_out[7:0]
  output logic       m_axis_tuser,  // found
  output logic       m_axis_tlast
);

  nlp_pkg::dp_cmd_t cmd;
  nlp_pkg::dp_sts_t sts;

  // sequencer
  nlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // store, pointers and output register
  nlp_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .char_i  (s_axis_tdata),
    .char_o  (m_axis_tdata),
    .found_o (m_axis_tuser),
    .last_o  (m_axis_tlast),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready)
  );

endmodule

// ===== bench/tb_next_lexicographic_permutation_core.sv =====
// one result item of the permutation stream
typedef struct packed {
  logic [7:0] ch;
  logic       found;
  logic       last;
} perm_item_t;

// tracks the word being loaded and holds the permutation items still owed
class perm_scoreboard;
  logic [7:0]  word[nlp_pkg::MAX_LEN];
  int unsigned word_len;
  perm_item_t  owed_q[$];
  int unsigned mismatches;

  function new();
    word_len   = 0;
    mismatches = 0;
  endfunction

  // rearrange the first n characters into the next greater order
  function bit advance_word(int unsigned n);
    int         piv;
    int         succ;
    int         lo;
    int         hi;
    logic [7:0] tmp;
    if (n < 2) return 1'b0;
    piv = int'(n) - 2;
    while (piv >= 0 && word[piv] >= word[piv + 1]) piv--;
    if (piv < 0) return 1'b0;
    // rightmost character above the pivot is the smallest one above it
    succ = int'(n) - 1;
    while (word[succ] <= word[piv]) succ--;
    tmp        = word[piv];
    word[piv]  = word[succ];
    word[succ] = tmp;
    // descending suffix becomes ascending
    lo = piv + 1;
    hi = int'(n) - 1;
    while (lo < hi) begin
      tmp      = word[lo];
      word[lo] = word[hi];
      word[hi] = tmp;
      lo++;
      hi--;
    end
    return 1'b1;
  endfunction

  // accepted request: store the character, on the final one queue the new word or the not-found item
  function void note_char(logic [7:0] c, logic fin);
    int unsigned n;
    perm_item_t  it;
    if (word_len < nlp_pkg::MAX_LEN) begin
      word[word_len] = c;
      word_len++;
    end
    if (!fin) return;
    n        = word_len;
    word_len = 0;
    if (!advance_word(n)) begin
      it.ch    = 8'd0;
      it.found = 1'b0;
      it.last  = 1'b1;
      owed_q.push_back(it);
    end else begin
      for (int unsigned k = 0; k < n; k++) begin
        it.ch    = word[k];
        it.found = 1'b1;
        it.last  = (k + 1 == n);
        owed_q.push_back(it);
      end
    end
  endfunction

  // compare one output item with the oldest owed one
  function void check_item(perm_item_t got);
    perm_item_t want;
    if (owed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected output: char=%02h found=%b last=%b",
                 got.ch, got.found, got.last);
      return;
    end
    want = owed_q.pop_front();
    if (got.ch !== want.ch || got.found !== want.found || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected char=%02h found=%b last=%b, got char=%02h found=%b last=%b",
                 want.ch, want.found, want.last, got.ch, got.found, got.last);
    end
  endfunction

  function int unsigned pending();
    return owed_q.size();
  endfunction
endclass

module tb_next_lexicographic_permutation_core;

  localparam int unsigned ITEM_TARGET = 310;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 400;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  perm_scoreboard sb;
  logic [7:0]     word_q[$];
  int unsigned    items_sent;
  int unsigned    cycles = 0;
  bit             calm;

  next_lexicographic_permutation_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // random gap, about 7 in a hundred outside the calm stretch
  function automatic bit take_gap();
    return !calm && ($urandom_range(99) < 7);
  endfunction

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= !take_gap();
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_item('{ch: m_axis_tdata, found: m_axis_tuser, last: m_axis_tlast});
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // present every character of word_q, the last one flagged
  task automatic send_word();
    for (int k = 0; k < word_q.size(); k++) begin
      while (take_gap()) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= word_q[k];
      s_axis_tlast  <= (k == word_q.size() - 1);
      do @(posedge clk_i); while (!s_axis_tready);
      sb.note_char(word_q[k], k == word_q.size() - 1);
      items_sent++;
    end
  endtask

  // random word of a random shape
  task automatic random_word();
    int unsigned r;
    int unsigned len;
    int unsigned shape;
    logic [7:0]  base;
    r = $urandom_range(99);
    if (r < 70)      len = $urandom_range(8, 1);
    else if (r < 90) len = $urandom_range(31, 9);
    else if (r < 96) len = nlp_pkg::MAX_LEN;
    else             len = $urandom_range(nlp_pkg::MAX_LEN + 8, nlp_pkg::MAX_LEN + 1);
    shape = $urandom_range(9);
    base  = 8'($urandom_range(252, 1));
    word_q.delete();
    for (int unsigned k = 0; k < len; k++) begin
      // narrow alphabet gives repeated characters
      if (shape < 4) word_q.push_back(8'($urandom_range(255, 1)));
      else           word_q.push_back(base + 8'($urandom_range(3)));
    end
    if (shape == 8) word_q.rsort();
    if (shape == 9) word_q.sort();
    send_word();
  endtask

  initial begin
    sb            = new();
    calm          = 1'b0;
    items_sent    = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tlast  = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single character, extremes, equal, ascending, descending, mixed orders
    word_q = '{8'd255};                    send_word();
    word_q = '{8'd1, 8'd255};              send_word();
    word_q = '{8'd255, 8'd1};              send_word();
    word_q = '{8'd7, 8'd7};                send_word();
    word_q = '{8'd1, 8'd2, 8'd3};          send_word();
    word_q = '{8'd3, 8'd2, 8'd1};          send_word();
    word_q = '{8'd1, 8'd3, 8'd2};          send_word();
    word_q = '{8'd1, 8'd1, 8'd2};          send_word();
    word_q = '{8'd128, 8'd127, 8'h55, 8'hAA}; send_word();

    // random words, with a calm stretch in the middle
    while (items_sent < ITEM_TARGET) begin
      calm = (items_sent >= 120 && items_sent < 200);
      random_word();
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
